// File: rtl/core/ptrm_pkg.sv
// Shared types, codes and page geometry helpers for the page table range mapper.
`default_nettype none

package ptrm_pkg;

  localparam int VW = 50;
  localparam int PW = 53;

  typedef logic [PW-1:0] alu_word_t;
  typedef logic [PW:0]   alu_res_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_REMAP       = 3'd1;
  localparam logic [2:0] ST_NO_TABLE    = 3'd2;
  localparam logic [2:0] ST_BAD_DESCENT = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;

  localparam logic [63:0] CLEAR_WORD       = 64'h102;
  localparam logic [11:0] TABLE_FLAGS      = 12'h103;
  localparam logic [11:0] SMALL_LEAF_FLAGS = 12'h103;
  localparam logic [11:0] LARGE_LEAF_FLAGS = 12'h183;
  localparam int          PRESENT_POS      = 0;
  localparam int          PS_POS           = 7;

  function automatic alu_word_t level_span(input logic [1:0] lvl);
    alu_word_t s;
    case (lvl)
      2'd2:    s = alu_word_t'(1) << 21;
      2'd3:    s = alu_word_t'(1) << 30;
      default: s = alu_word_t'(1) << 12;
    endcase
    return s;
  endfunction

  function automatic alu_word_t level_offset_mask(input logic [1:0] lvl);
    alu_word_t m;
    case (lvl)
      2'd2:    m = {{(PW-21){1'b0}}, {21{1'b1}}};
      2'd3:    m = {{(PW-30){1'b0}}, {30{1'b1}}};
      default: m = {{(PW-12){1'b0}}, {12{1'b1}}};
    endcase
    return m;
  endfunction

  function automatic logic [8:0] level_index(input logic [VW-1:0] v, input logic [2:0] lv);
    logic [8:0] ix;
    case (lv)
      3'd4:    ix = v[47:39];
      3'd3:    ix = v[38:30];
      3'd2:    ix = v[29:21];
      default: ix = v[20:12];
    endcase
    return ix;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/page_table_range_mapper.sv
// Top level: four-level page table builder with internal table store and sequencer.
//
//  channel  | handshake          | words
//  ---------+--------------------+------------------------------------------------
//  input    | start / busy       | operation, virt/phys address, size, level, index
//  result   | out_valid strobe   | status, existing address, read data, tables used
//  config   | cfg_wr_en          | table_base (52 bits)
//
//  A read passes through the read-start and read-wait states before the strobe; a map
//  first aligns its range, then per page walks the levels down to the leaf and steps
//  both addresses, all through the one shared adder and the table store, one access
//  a cycle. After reset a clearing pass writes every store word (TABLE_PAGES * 512),
//  with busy high; config writes are taken meanwhile.
//  The result strobe lasts one cycle and cannot be stalled; busy is low in that cycle.
`default_nettype none

module page_table_range_mapper import ptrm_pkg::*; #(
  parameter int TABLE_PAGES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        in_operation,
  input  wire logic [47:0] in_virt_address,
  input  wire logic [51:0] in_phys_address,
  input  wire logic [47:0] in_size_bytes,
  input  wire logic [1:0]  in_page_level,
  input  wire logic [14:0] in_read_index,
  output      logic        out_valid,
  output      logic [2:0]  out_status,
  output      logic [51:0] out_existing_address,
  output      logic [63:0] out_read_data,
  output      logic [6:0]  out_tables_used,
  input  wire logic        cfg_wr_en,
  input  wire logic [51:0] cfg_wr_data
);

  localparam int STORE_WORDS = TABLE_PAGES * 512;
  localparam int TW          = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW          = TW + 9;
  localparam int NW          = $clog2(TABLE_PAGES + 1);
  localparam int IW          = (AW + 1 > 15) ? AW + 1 : 15;
  localparam int UW          = (NW > 7) ? NW : 7;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_RDS    = 4'd2;
  localparam logic [3:0] S_RDW    = 4'd3;
  localparam logic [3:0] S_ALIGN1 = 4'd4;
  localparam logic [3:0] S_ALIGN2 = 4'd5;
  localparam logic [3:0] S_PAGE   = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_DESC   = 4'd9;
  localparam logic [3:0] S_ADVV   = 4'd10;
  localparam logic [3:0] S_ADVP   = 4'd11;

  logic [3:0]    state_r,     state_nxt;
  logic [AW-1:0] clr_r,       clr_nxt;
  logic [NW-1:0] next_free_r, next_free_nxt;
  logic [51:0]   table_base_r;
  logic          out_valid_r, out_valid_nxt;

  logic [VW-1:0] v_r,       v_nxt;
  logic [VW-1:0] end_r,     end_nxt;
  logic [PW-1:0] p_r,       p_nxt;
  logic [47:0]   size_r,    size_nxt;
  logic [1:0]    lvl_r,     lvl_nxt;
  logic [14:0]   idx_r,     idx_nxt;
  logic [2:0]    lv_r,      lv_nxt;
  logic [TW-1:0] t_r,       t_nxt;
  logic [39:0]   ent_addr_r, ent_addr_nxt;
  logic          ent_ps_r,  ent_ps_nxt;
  logic [2:0]    status_r,  status_nxt;
  logic [51:0]   exist_r,   exist_nxt;
  logic [63:0]   rdata_r,   rdata_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  alu_word_t     alu_a;
  alu_word_t     alu_b;
  logic          alu_sub;
  alu_res_t      alu_res;

  alu_word_t     pg_size;
  alu_word_t     pg_mask;
  logic [51:0]   base;
  logic [AW-1:0] walk_addr;
  logic [IW-1:0] idx_ext;
  logic [39:0]   desc_d;
  logic [UW-1:0] used_ext;

  assign pg_size   = level_span(lvl_r);
  assign pg_mask   = level_offset_mask(lvl_r);
  assign base      = {table_base_r[51:12], 12'h000};
  assign walk_addr = {t_r, level_index(v_r, lv_r)};
  assign idx_ext   = IW'(idx_r);
  assign desc_d    = alu_res[51:12];
  assign used_ext  = UW'(next_free_r);

  ptrm_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptrm_alu u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  always_comb begin
    alu_a   = PW'(v_r & ~pg_mask[VW-1:0]);
    alu_b   = PW'(size_r);
    alu_sub = 1'b0;
    case (state_r)
      S_ALIGN2: begin
        alu_a = PW'(end_r);
        alu_b = pg_mask;
      end
      S_EVAL: begin
        alu_a = PW'(base);
        alu_b = PW'(next_free_r) << 12;
      end
      S_DESC: begin
        alu_a   = PW'({ent_addr_r, 12'h000});
        alu_b   = PW'(base);
        alu_sub = 1'b1;
      end
      S_ADVV: begin
        alu_a = PW'(v_r);
        alu_b = pg_size;
      end
      S_ADVP: begin
        alu_a = p_r;
        alu_b = pg_size;
      end
      default: begin
        alu_a   = PW'(v_r & ~pg_mask[VW-1:0]);
        alu_b   = PW'(size_r);
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    next_free_nxt = next_free_r;
    out_valid_nxt = 1'b0;
    v_nxt         = v_r;
    end_nxt       = end_r;
    p_nxt         = p_r;
    size_nxt      = size_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    lv_nxt        = lv_r;
    t_nxt         = t_r;
    ent_addr_nxt  = ent_addr_r;
    ent_ps_nxt    = ent_ps_r;
    status_nxt    = status_r;
    exist_nxt     = exist_r;
    rdata_nxt     = rdata_r;
    ram_we        = 1'b0;
    ram_waddr     = walk_addr;
    ram_wdata     = CLEAR_WORD;
    ram_re        = 1'b0;
    ram_raddr     = walk_addr;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt      = VW'(in_virt_address);
          p_nxt      = PW'(in_phys_address);
          size_nxt   = in_size_bytes;
          lvl_nxt    = (in_page_level == 2'd0) ? 2'd1 : in_page_level;
          idx_nxt    = in_read_index;
          status_nxt = ST_OK;
          exist_nxt  = '0;
          rdata_nxt  = '0;
          state_nxt  = in_operation ? S_RDS : S_ALIGN1;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = CLEAR_WORD;
        if (clr_r == AW'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_RDS: begin
        if (idx_ext < IW'(STORE_WORDS)) begin
          ram_re    = 1'b1;
          ram_raddr = idx_ext[AW-1:0];
          state_nxt = S_RDW;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RDW: begin
        rdata_nxt     = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ALIGN1: begin
        v_nxt     = v_r & ~pg_mask[VW-1:0];
        p_nxt     = p_r & ~pg_mask;
        end_nxt   = alu_res[VW-1:0];
        state_nxt = S_ALIGN2;
      end
      S_ALIGN2: begin
        end_nxt   = alu_res[VW-1:0] & ~pg_mask[VW-1:0];
        state_nxt = S_PAGE;
      end
      S_PAGE: begin
        if (v_r >= end_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (v_r[VW-1:48] != '0 || p_r[PW-1]) begin
          status_nxt    = ST_OVERFLOW;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lv_nxt    = 3'd4;
          t_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (lv_r == {1'b0, lvl_r}) begin
          if (ram_rdata[PRESENT_POS]) begin
            status_nxt    = ST_REMAP;
            exist_nxt     = {ram_rdata[51:12], 12'h000};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {12'h000, p_r[51:12],
                         (lvl_r != 2'd1) ? LARGE_LEAF_FLAGS : SMALL_LEAF_FLAGS};
            state_nxt = S_ADVV;
          end
        end else if (!ram_rdata[PRESENT_POS]) begin
          if (next_free_r >= NW'(TABLE_PAGES)) begin
            status_nxt    = ST_NO_TABLE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ram_we        = 1'b1;
            ram_wdata     = {12'h000, alu_res[51:12], TABLE_FLAGS};
            ent_addr_nxt  = alu_res[51:12];
            ent_ps_nxt    = TABLE_FLAGS[PS_POS];
            next_free_nxt = next_free_r + NW'(1);
            state_nxt     = S_DESC;
          end
        end else begin
          ent_addr_nxt = ram_rdata[51:12];
          ent_ps_nxt   = ram_rdata[PS_POS];
          state_nxt    = S_DESC;
        end
      end
      S_DESC: begin
        if (ent_ps_r || alu_res[PW] || desc_d >= 40'(next_free_r)) begin
          status_nxt    = ST_BAD_DESCENT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          t_nxt     = desc_d[TW-1:0];
          lv_nxt    = lv_r - 3'd1;
          state_nxt = S_RD;
        end
      end
      S_ADVV: begin
        v_nxt     = alu_res[VW-1:0];
        state_nxt = S_ADVP;
      end
      S_ADVP: begin
        p_nxt     = alu_res[PW-1:0];
        state_nxt = S_PAGE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      next_free_r  <= NW'(1);
      table_base_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      next_free_r  <= next_free_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        table_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    end_r      <= end_nxt;
    p_r        <= p_nxt;
    size_r     <= size_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    lv_r       <= lv_nxt;
    t_r        <= t_nxt;
    ent_addr_r <= ent_addr_nxt;
    ent_ps_r   <= ent_ps_nxt;
    status_r   <= status_nxt;
    exist_r    <= exist_nxt;
    rdata_r    <= rdata_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_existing_address = exist_r;
  assign out_read_data        = rdata_r;
  assign out_tables_used      = used_ext[6:0];

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r >= NW'(1)) && (next_free_r <= NW'(TABLE_PAGES)))
    else $error("table counter out of range");

  a_free_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r != $past(next_free_r)) |->
      ($past(state_r) == S_EVAL && next_free_r == $past(next_free_r) + NW'(1)))
    else $error("table counter moved other than by one allocation");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_EVAL))
    else $error("store write outside clear or evaluate");

  a_walk_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (NW'(t_r) < next_free_r))
    else $error("walk reads an unallocated table");

endmodule

`default_nettype wire

// File: rtl/core/ptrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ptrm_alu.sv
// Shared add/subtract unit used for alignment, allocation, descent and stepping.
`default_nettype none

module ptrm_alu import ptrm_pkg::*; (
  input  wire alu_word_t opa,
  input  wire alu_word_t opb,
  input  wire logic      sub,
  output      alu_res_t  res
);

  // top bit is carry on add, borrow on subtract
  assign res = sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the page table range mapper: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import ptrm_pkg::*;

  localparam int          N_TABLES      = 64;
  localparam int          STORE_DEPTH   = N_TABLES * 512;
  localparam int          N_ANCHORS     = 6;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned RUN_LIMIT     = 2_000_000;

  localparam logic        OP_MAP   = 1'b0;
  localparam logic        OP_READ  = 1'b1;
  localparam logic [1:0]  LVL_NONE = 2'd0;
  localparam logic [1:0]  LVL_4K   = 2'd1;
  localparam logic [1:0]  LVL_2M   = 2'd2;
  localparam logic [1:0]  LVL_1G   = 2'd3;

  localparam logic [63:0] ADDR_FIELD = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] VA_LIMIT   = 64'h0001_0000_0000_0000;
  localparam logic [63:0] PA_LIMIT   = 64'h0010_0000_0000_0000;

  typedef struct packed {
    logic        op;
    logic [47:0] virt;
    logic [51:0] phys;
    logic [47:0] size;
    logic [1:0]  lvl;
    logic [14:0] idx;
  } map_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] existing;
    logic [63:0] rd;
    logic [6:0]  tables;
  } map_reply_t;

  typedef struct packed {
    map_cmd_t   cmd;
    logic       fixed;
    map_reply_t reply;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [47:0] in_virt_address = '0;
  logic [51:0] in_phys_address = '0;
  logic [47:0] in_size_bytes = '0;
  logic [1:0]  in_page_level = LVL_4K;
  logic [14:0] in_read_index = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [51:0] out_existing_address;
  logic [63:0] out_read_data;
  logic [6:0]  out_tables_used;
  logic        cfg_wr_en = 1'b0;
  logic [51:0] cfg_wr_data = '0;

  logic [63:0]   pt_store [STORE_DEPTH];
  int unsigned   tables_alloc;
  logic [63:0]   pt_base;
  logic [63:0]   anchors [N_ANCHORS];
  map_reply_t    pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  page_table_range_mapper #(.TABLE_PAGES(N_TABLES)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_virt_address      (in_virt_address),
    .in_phys_address      (in_phys_address),
    .in_size_bytes        (in_size_bytes),
    .in_page_level        (in_page_level),
    .in_read_index        (in_read_index),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_existing_address (out_existing_address),
    .out_read_data        (out_read_data),
    .out_tables_used      (out_tables_used),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] walk_and_map(input logic [63:0] virt, input logic [63:0] phys,
                                              input logic [63:0] size, input int unsigned lvl,
                                              output logic [63:0] existing);
    int unsigned shift, lv, tbl, slot, n, k;
    logic [63:0] psz, base, v, v_end, p, e, a, d;
    existing = '0;
    shift = 12 + 9 * (lvl - 1);
    psz = 64'd1 << shift;
    base = pt_base & ADDR_FIELD;
    v = virt & ~(psz - 1);
    v_end = (v + size + psz - 1) & ~(psz - 1);
    p = phys & ~(psz - 1);
    while (v < v_end) begin
      if (v >= VA_LIMIT || p >= PA_LIMIT) return ST_OVERFLOW;
      tbl = 0;
      for (lv = 4; lv > lvl; lv--) begin
        slot = tbl * 512 + int'((v >> (9 * lv + 3)) & 64'd511);
        e = pt_store[slot];
        if (!e[PRESENT_POS]) begin
          if (tables_alloc >= N_TABLES) return ST_NO_TABLE;
          n = tables_alloc;
          tables_alloc++;
          for (k = 0; k < 512; k++) pt_store[n * 512 + k] = CLEAR_WORD;
          e = CLEAR_WORD | ((base + 64'(n) * 4096) & ADDR_FIELD);
          e[PRESENT_POS] = 1'b1;
          pt_store[slot] = e;
        end
        if (e[PS_POS]) return ST_BAD_DESCENT;
        a = e & ADDR_FIELD;
        if (a < base) return ST_BAD_DESCENT;
        d = (a - base) >> 12;
        if (d >= tables_alloc) return ST_BAD_DESCENT;
        tbl = int'(d);
      end
      slot = tbl * 512 + int'((v >> (9 * lvl + 3)) & 64'd511);
      e = pt_store[slot];
      if (e[PRESENT_POS]) begin
        existing = e & ADDR_FIELD;
        return ST_REMAP;
      end
      e = CLEAR_WORD | (p & ADDR_FIELD);
      e[PRESENT_POS] = 1'b1;
      e[PS_POS] = (lvl > 1);
      pt_store[slot] = e;
      v += psz;
      p += psz;
    end
    return ST_OK;
  endfunction

  function automatic map_reply_t compute_result(input map_cmd_t c);
    map_reply_t r;
    int unsigned lvl;
    logic [63:0] ex;
    r = '0;
    ex = '0;
    lvl = (c.lvl == LVL_NONE) ? 1 : c.lvl;
    if (c.op == OP_READ) begin
      if (c.idx < STORE_DEPTH) r.rd = pt_store[c.idx];
    end else if (c.size != 0) begin
      r.status = walk_and_map(c.virt, c.phys, c.size, lvl, ex);
    end
    r.existing = ex[51:0];
    r.tables = tables_alloc[6:0];
    return r;
  endfunction

  function automatic map_cmd_t random_cmd();
    map_cmd_t c;
    int unsigned kind, shift, npg, eff;
    logic [63:0] psz, win, v, p, s;
    v = rand64();
    p = rand64();
    s = rand64();
    c.op = OP_MAP;
    c.virt = v[47:0];
    c.phys = p[51:0];
    c.size = s[47:0];
    c.idx = 15'($urandom);
    c.lvl = 2'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      c.op = OP_READ;
      if ($urandom_range(0, 4) != 0) c.idx = 15'($urandom_range(0, tables_alloc * 512 - 1));
      return c;
    end
    kind = $urandom_range(0, 99);
    c.lvl = kind < 60 ? LVL_4K : kind < 80 ? LVL_2M : kind < 93 ? LVL_1G : LVL_NONE;
    eff = (c.lvl == LVL_NONE) ? 1 : c.lvl;
    shift = 12 + 9 * (eff - 1);
    psz = 64'd1 << shift;
    win = (64'd1 << (shift + 9)) - 1;
    kind = $urandom_range(0, 99);
    if (kind < 85) v = (anchors[$urandom_range(0, N_ANCHORS - 1)] & ~win) | (rand64() & win);
    else if (kind < 95) v = rand64();
    else v = VA_LIMIT - $urandom_range(1, 3) * psz + (rand64() & (psz - 1));
    c.virt = v[47:0];
    if ($urandom_range(0, 9) == 0) p = PA_LIMIT - $urandom_range(1, 3) * psz + (p & (psz - 1));
    c.phys = p[51:0];
    npg = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
    s = (npg - 1) * psz + (rand64() & (psz - 1)) + 1;
    c.size = s[47:0];
    if (kind >= 95 && $urandom_range(0, 1) == 0) c.size = '1;
    if ($urandom_range(0, 49) == 0) c.size = '0;
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatch_count++;
    $display("%0t %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic issue(input map_cmd_t c, input logic fixed, input map_reply_t typed);
    map_reply_t r;
    start <= 1'b1;
    in_operation <= c.op;
    in_virt_address <= c.virt;
    in_phys_address <= c.phys;
    in_size_bytes <= c.size;
    in_page_level <= c.lvl;
    in_read_index <= c.idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = compute_result(c);
    pending_results.push_back(fixed ? typed : r);
  endtask

  task automatic add_row(input logic op, input logic [47:0] virt, input logic [51:0] phys,
                         input logic [47:0] size, input logic [1:0] lvl, input logic [14:0] idx,
                         input logic fixed, input logic [2:0] status, input logic [51:0] existing,
                         input logic [63:0] rd, input logic [6:0] tables);
    directed_row_t row;
    row.cmd = '{op, virt, phys, size, lvl, idx};
    row.fixed = fixed;
    row.reply = '{status, existing, rd, tables};
    directed_rows.push_back(row);
  endtask

  task automatic load_table_base(input logic [51:0] value);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pt_base = {12'h0, value};
  endtask

  task automatic run_bursts(input int unsigned count);
    int unsigned sent, burst, gap, j;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (j = 0; j < burst && sent < count; j++) begin
        issue(random_cmd(), 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (sent >= count && gap == 0) gap = 1;
      if (gap != 0) begin
        start <= 1'b0;
        if ($urandom_range(0, 29) == 0) begin
          while (pending_results.size() != 0) @(posedge clk);
        end
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    map_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("word with nothing pending", out_read_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) flag_mismatch("status", out_status, want.status);
        if (out_existing_address !== want.existing)
          flag_mismatch("existing_address", out_existing_address, want.existing);
        if (out_read_data !== want.rd) flag_mismatch("read_data", out_read_data, want.rd);
        if (out_tables_used !== want.tables)
          flag_mismatch("tables_used", out_tables_used, want.tables);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int k;
    logic [63:0] mid_base;
    for (k = 0; k < STORE_DEPTH; k++) pt_store[k] = CLEAR_WORD;
    tables_alloc = 1;
    pt_base = '0;
    for (k = 0; k < N_ANCHORS; k++) anchors[k] = rand64() & 64'h0000_FFFF_FFFF_FFFF;

    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd0, 1'b1, ST_OK, '0, CLEAR_WORD, 7'd1);
    add_row(OP_READ, '1, '1, '1, LVL_1G, 15'h7FFF, 1'b1, ST_OK, '0, CLEAR_WORD, 7'd1);
    add_row(OP_MAP, '1, '1, '0, LVL_1G, 15'h7FFF, 1'b1, ST_OK, '0, '0, 7'd1);
    add_row(OP_MAP, '0, '0, 48'd1, LVL_4K, 15'd0, 1'b1, ST_OK, '0, '0, 7'd4);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd0, 1'b1, ST_OK, '0, 64'h1103, 7'd4);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd512, 1'b1, ST_OK, '0, 64'h2103, 7'd4);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd1024, 1'b1, ST_OK, '0, 64'h3103, 7'd4);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd1536, 1'b1, ST_OK, '0, 64'h103, 7'd4);
    add_row(OP_MAP, '0, '0, 48'h1000, LVL_4K, 15'd0, 1'b1, ST_REMAP, '0, '0, 7'd4);
    add_row(OP_MAP, 48'h1000, '1, 48'h1000, LVL_NONE, 15'd0, 1'b1, ST_OK, '0, '0, 7'd4);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd1537, 1'b1, ST_OK, '0,
            64'h000F_FFFF_FFFF_F103, 7'd4);
    add_row(OP_MAP, 48'h2000, 52'hF_FFFF_FFFF_F000, 48'h2000, LVL_4K, 15'd0, 1'b1,
            ST_OVERFLOW, '0, '0, 7'd4);
    add_row(OP_MAP, 48'hFFFF_FFFF_F000, '0, '1, LVL_4K, 15'd0, 1'b1, ST_OVERFLOW, '0, '0, 7'd7);
    add_row(OP_MAP, 48'h4000_0000, 52'h1234_5678, 48'h20_0001, LVL_2M, 15'd0, 1'b0, '0, '0, '0,
            '0);
    add_row(OP_MAP, 48'h80_0000_0000, 52'hF_FFFF_C000_0000, 48'h8000_0000, LVL_1G, 15'd0, 1'b0,
            '0, '0, '0, '0);
    add_row(OP_MAP, 48'h4000_1000, 52'h5_5555_5555_5555, 48'h1000, LVL_4K, 15'd0, 1'b0, '0, '0,
            '0, '0);
    add_row(OP_MAP, '0, 52'hA_AAAA_AAAA_AAAA, 48'd1, LVL_2M, 15'd0, 1'b0, '0, '0, '0, '0);
    add_row(OP_MAP, '0, '0, 48'd1, LVL_1G, 15'd0, 1'b0, '0, '0, '0, '0);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'h5555, 1'b0, '0, '0, '0, '0);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'h2AAA, 1'b0, '0, '0, '0, '0);
    add_row(OP_READ, '0, '0, '0, LVL_4K, 15'd3584, 1'b0, '0, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    load_table_base(52'h0);
    foreach (directed_rows[k]) issue(directed_rows[k].cmd, directed_rows[k].fixed,
                                     directed_rows[k].reply);
    start <= 1'b0;
    @(posedge clk);
    run_bursts(180);

    mid_base = rand64();
    load_table_base(mid_base[51:0]);
    run_bursts(90);

    load_table_base(52'hF_FFFF_FFFF_FFFF);
    run_bursts(40);

    load_table_base(52'h0);
    run_bursts(120);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
